[hdl/edc_pkg.sv]
`default_nettype none

package edc_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int WINDOW_BITS = 64;
    localparam int COUNT_BITS  = 6;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    typedef struct packed {
        logic [WINDOW_BITS-1:0] code_word;
        logic [COUNT_BITS-1:0]  bit_count;
        logic [VALUE_BITS-1:0]  value_out;
        logic                   error_flag;
    } t_result;

endpackage

`default_nettype wire

[hdl/elias_delta_codec.sv]
// Elias delta codec, one item per clock when not stalled. Each item is an encode
// (i_operation = 0) of i_value_in, giving the code in o_code_word in stream
// order (first bit in bit 0, unused bits zero) and its length in o_bit_count,
// or a decode (i_operation = 1) of the stream bits in i_bit_window (first bit
// in bit 0), giving the value in o_value_out and the bits consumed in
// o_bit_count. Fields that do not apply to the operation read zero.
// o_error_flag marks an encode of zero or of a value at or above
// 2^VALUE_WIDTH, and a decode with more than five leading zeros (an all-zero
// window included) or with a length field above VALUE_WIDTH; all other
// fields are zero then. An item goes through one input register, one pass
// through the encoder or decoder logic (priority encoders and barrel
// shifters) and one result register, which drives o_valid. Both stages advance
// independently, so a new item is taken every cycle while results are drained,
// and a stall on the output side backs up through o_ready without losing data.
// No state is kept between items.
`default_nettype none

module elias_delta_codec #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_operation,
    input  logic [edc_pkg::VALUE_BITS-1:0]  i_value_in,
    input  logic [edc_pkg::WINDOW_BITS-1:0] i_bit_window,

    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [edc_pkg::WINDOW_BITS-1:0] o_code_word,
    output logic [edc_pkg::COUNT_BITS-1:0]  o_bit_count,
    output logic [edc_pkg::VALUE_BITS-1:0]  o_value_out,
    output logic                            o_error_flag
);

    // input stage
    logic                            r_in_valid;
    logic                            r_op;
    logic [edc_pkg::VALUE_BITS-1:0]  r_value;
    logic [edc_pkg::WINDOW_BITS-1:0] r_window;

    // result stage
    logic                            r_out_valid;
    edc_pkg::t_result                r_result;

    edc_pkg::t_result                enc_result;
    edc_pkg::t_result                dec_result;
    edc_pkg::t_result                n_result;

    logic                            out_free;
    logic                            in_take;

    // result register can load when empty or being drained this cycle
    assign out_free = !r_out_valid || i_ready;
    // input register can load when empty or moving on to the result stage
    assign o_ready  = !r_in_valid || out_free;
    assign in_take  = i_valid && o_ready;

    edc_encoder #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_encoder (
        .i_value  (r_value),
        .o_result (enc_result)
    );

    edc_decoder #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_decoder (
        .i_window (r_window),
        .o_result (dec_result)
    );

    assign n_result = (r_op == edc_pkg::OP_DECODE) ? dec_result : enc_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op     <= i_operation;
            r_value  <= i_value_in;
            r_window <= i_bit_window;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_code_word  = r_result.code_word;
    assign o_bit_count  = r_result.bit_count;
    assign o_value_out  = r_result.value_out;
    assign o_error_flag = r_result.error_flag;

endmodule

`default_nettype wire

[hdl/edc_encoder.sv]
`default_nettype none

module edc_encoder #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic [edc_pkg::VALUE_BITS-1:0] i_value,
    output edc_pkg::t_result               o_result
);

    localparam logic [edc_pkg::VALUE_BITS-1:0] VALUE_MASK =
        32'((64'd1 << VALUE_WIDTH) - 64'd1);

    logic [5:0]  len;
    logic [2:0]  len_len;
    logic        err;
    logic [31:0] tail;
    logic [63:0] msb_code;
    logic [63:0] rev_code;
    logic [5:0]  count;
    logic [5:0]  shift;

    always_comb begin
        // bit length of x
        len = '0;
        for (int i = 0; i < 32; i++) begin
            if (i_value[i]) begin
                len = 6'(i + 1);
            end
        end
        // bit length of L
        len_len = '0;
        for (int i = 0; i < 6; i++) begin
            if (len[i]) begin
                len_len = 3'(i + 1);
            end
        end
        err = (i_value == '0) || ((i_value & ~VALUE_MASK) != '0);

        // code as an MSB-first number: L then x without its top bit;
        // the leading zeros come from the number's own width
        tail     = i_value & ~(32'd1 << 5'(len - 6'd1));
        msb_code = ({58'd0, len} << 5'(len - 6'd1)) | {32'd0, tail};
        count    = 6'({len_len, 1'b0}) - 6'd2 + len;

        // flip into stream order, then drop the unused low end
        for (int i = 0; i < 64; i++) begin
            rev_code[63-i] = msb_code[i];
        end
        shift = 6'(7'd64 - {1'b0, count});

        o_result.value_out  = '0;
        o_result.error_flag = err;
        if (err) begin
            o_result.code_word = '0;
            o_result.bit_count = '0;
        end else begin
            o_result.code_word = rev_code >> shift;
            o_result.bit_count = count;
        end
    end

endmodule

`default_nettype wire

[hdl/edc_decoder.sv]
`default_nettype none

module edc_decoder #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic [edc_pkg::WINDOW_BITS-1:0] i_window,
    output edc_pkg::t_result                o_result
);

    logic [2:0]  zeros;
    logic        err_lz;
    logic [4:0]  len_bits;
    logic [4:0]  len_rev;
    logic [5:0]  len;
    logic [3:0]  tail_pos;
    logic [30:0] tail;
    logic [31:0] tail_rev;
    logic [31:0] value;
    logic        err;

    always_comb begin
        // leading zeros, only six bits matter
        err_lz = (i_window[5:0] == 6'd0);
        zeros  = '0;
        for (int i = 5; i >= 0; i--) begin
            if (i_window[i]) begin
                zeros = 3'(i);
            end
        end

        // L: implicit one then 'zeros' bits, MSB read first
        len_bits = 5'(i_window[11:1] >> zeros);
        for (int i = 0; i < 5; i++) begin
            len_rev[4-i] = len_bits[i];
        end
        len = (6'd1 << zeros) | 6'({1'b0, len_rev} >> (3'd5 - zeros));
        err = err_lz || ({1'b0, len} > 7'(VALUE_WIDTH));

        // value: implicit top one then L-1 bits, MSB read first
        tail_pos = 4'({zeros, 1'b0}) + 4'd1;
        tail     = 31'(i_window >> tail_pos);
        tail_rev[31] = 1'b0;
        for (int i = 0; i < 31; i++) begin
            tail_rev[30-i] = tail[i];
        end
        value = (32'd1 << 5'(len - 6'd1)) | (tail_rev >> 6'(6'd32 - len));

        o_result.code_word  = '0;
        o_result.error_flag = err;
        if (err) begin
            o_result.bit_count = '0;
            o_result.value_out = '0;
        end else begin
            o_result.bit_count = 6'({zeros, 1'b0}) + len;
            o_result.value_out = value;
        end
    end

endmodule

`default_nettype wire

[tb/elias_delta_codec_tb.sv]
`default_nettype none

module elias_delta_codec_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_BITS  = edc_pkg::VALUE_BITS;
    localparam int WINDOW_BITS = edc_pkg::WINDOW_BITS;
    localparam int COUNT_BITS  = edc_pkg::COUNT_BITS;

    // Run limits. The slowest phases idle the sender or stall the receiver in
    // 74% of cycles. About 1900 items are run in all, so CYCLE_LIMIT leaves a
    // wide margin.
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 80;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 8;   // idle time after the last result
    localparam int PHASE_ITEMS = 400;

    // One item as offered on the input channel.
    typedef struct {
        logic                   op;
        logic [VALUE_BITS-1:0]  value;
        logic [WINDOW_BITS-1:0] window;
    } t_codec_item;

    // DUT ports
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic                   i_operation = edc_pkg::OP_ENCODE;
    logic [VALUE_BITS-1:0]  i_value_in = '0;
    logic [WINDOW_BITS-1:0] i_bit_window = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic [WINDOW_BITS-1:0] o_code_word;
    logic [COUNT_BITS-1:0]  o_bit_count;
    logic [VALUE_BITS-1:0]  o_value_out;
    logic                   o_error_flag;

    // Items waiting to be driven, and results predicted for accepted items.
    t_codec_item       pending_items[$];
    edc_pkg::t_result  expected_results[$];

    // Idle rates, percent of cycles; changed only between phases.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // Hold-off request: the stimulus bumps hold_req, the receiver notices the
    // change and holds i_ready low while it counts hold_cycles down from HOLD_CYCLES.
    int hold_req = 0;
    int hold_seen = 0;
    int hold_cycles = 0;

    int n_fail = 0;
    int n_checked = 0;
    int n_encodes = 0;
    int n_decodes = 0;
    int n_flagged = 0;
    int cycle_count = 0;

    t_codec_item       nxt_item;
    edc_pkg::t_result  accepted_pred;
    edc_pkg::t_result  want;

    elias_delta_codec #(
        .VALUE_WIDTH (VALUE_BITS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_operation  (i_operation),
        .i_value_in   (i_value_in),
        .i_bit_window (i_bit_window),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_code_word  (o_code_word),
        .o_bit_count  (o_bit_count),
        .o_value_out  (o_value_out),
        .o_error_flag (o_error_flag)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Codec prediction. Encode: bitlen(L)-1 zeros, L MSB first, then the
    // low L-1 bits of x MSB first, packed first bit at bit 0. Decode parses
    // the same layout from the bottom of the window. Any error zeroes all
    // fields except the flag. With 32-bit value_in and VALUE_WIDTH = 32 the
    // oversize-value case of encode cannot arise.
    // ------------------------------------------------------------------
    function automatic edc_pkg::t_result predict_codec(logic op, logic [VALUE_BITS-1:0] x,
                                                       logic [WINDOW_BITS-1:0] w);
        edc_pkg::t_result      r;
        int                    len;
        int                    llen;
        int                    pos;
        int                    zeros;
        int                    i;
        logic [VALUE_BITS-1:0] v;
        r = '0;
        if (op == edc_pkg::OP_ENCODE) begin
            if (x == '0) begin
                r.error_flag = 1'b1;
                return r;
            end
            len = 0;
            for (i = 0; i < VALUE_BITS; i++)
                if (x[i]) len = i + 1;
            llen = 0;
            for (i = 0; i < COUNT_BITS; i++)
                if (((len >> i) & 1) != 0) llen = i + 1;
            pos = llen - 1;                     // leading zeros
            for (i = llen - 1; i >= 0; i--) begin
                r.code_word[pos] = ((len >> i) & 1) != 0;
                pos++;
            end
            for (i = len - 2; i >= 0; i--) begin
                r.code_word[pos] = x[i];
                pos++;
            end
            r.bit_count = COUNT_BITS'(pos);
        end else begin
            if (w == '0) begin
                r.error_flag = 1'b1;
                return r;
            end
            zeros = 0;
            while (!w[zeros]) zeros++;
            if (zeros > 5) begin
                r.error_flag = 1'b1;
                return r;
            end
            pos = zeros + 1;                    // past the leading one of L
            len = 1;
            for (i = 0; i < zeros; i++) begin
                len = (len << 1) | int'(w[pos]);
                pos++;
            end
            if (len > VALUE_BITS) begin
                r.error_flag = 1'b1;
                return r;
            end
            v = '0;
            v[len-1] = 1'b1;
            for (i = len - 2; i >= 0; i--) begin
                v[i] = w[pos];
                pos++;
            end
            r.value_out = v;
            r.bit_count = COUNT_BITS'(pos);
        end
        return r;
    endfunction

    function automatic logic [WINDOW_BITS-1:0] rand_window();
        return {$urandom, $urandom};
    endfunction

    // A legal codeword for x at the bottom of the window, random bits above it.
    function automatic logic [WINDOW_BITS-1:0] coded_window(logic [VALUE_BITS-1:0] x);
        edc_pkg::t_result c;
        c = predict_codec(edc_pkg::OP_ENCODE, x, '0);
        return c.code_word | (rand_window() << c.bit_count);
    endfunction

    // Values spread over all bit lengths, not only the long ones.
    function automatic logic [VALUE_BITS-1:0] rand_value();
        return $urandom >> $urandom_range(0, VALUE_BITS - 1);
    endfunction

    task automatic push_item(logic op, logic [VALUE_BITS-1:0] x, logic [WINDOW_BITS-1:0] w);
        t_codec_item it;
        it.op = op;
        it.value = x;
        it.window = w;
        pending_items = {pending_items, it};
    endtask

    // Random mix: plain encodes, mostly well-formed decodes, plus decodes that
    // hit leading-zero limits, oversize lengths and empty or near-empty windows.
    task automatic push_random(int count);
        int                     k;
        int                     pick;
        logic [VALUE_BITS-1:0]  x;
        logic [WINDOW_BITS-1:0] w;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            x = $urandom;
            w = rand_window();
            if (pick < 35) begin
                x = ($urandom_range(0, 99) < 3) ? '0 : rand_value();
                push_item(edc_pkg::OP_ENCODE, x, w);
            end else begin
                if (pick < 75) begin
                    w = coded_window(rand_value() | 32'h1 << $urandom_range(0, 31));
                end else if (pick < 85) begin
                    w = (w | 64'h1) << $urandom_range(0, 8);
                end else if (pick < 93) begin
                    // five leading zeros, length field 32..63
                    w[4:0] = '0;
                    w[5] = 1'b1;
                end else if (pick < 97) begin
                    // keep the fully random window
                end else begin
                    w = ($urandom_range(0, 3) == 0) ? '0 : w << $urandom_range(6, 63);
                end
                push_item(edc_pkg::OP_DECODE, x, w);
            end
        end
    endtask

    // Wait until every queued item has gone in and every result has come out.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || i_valid || expected_results.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Driver: records the accepted item, then offers the next one (or idles)
    // once the current offer has been taken. Valid stays up until accepted.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                accepted_pred = predict_codec(i_operation, i_value_in, i_bit_window);
                expected_results = {expected_results, accepted_pred};
                if (i_operation == edc_pkg::OP_ENCODE) n_encodes++;
                else n_decodes++;
                if (accepted_pred.error_flag) n_flagged++;
            end
            if (!i_valid || o_ready) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt_item = pending_items.pop_front();
                    i_valid      <= 1'b1;
                    i_operation  <= nxt_item.op;
                    i_value_in   <= nxt_item.value;
                    i_bit_window <= nxt_item.window;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted result against the oldest prediction and
    // drives i_ready, including the long hold-off when one is requested.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready     <= 1'b0;
            hold_cycles <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no item outstanding: code_word %h bit_count %0d",
                           o_code_word, o_bit_count);
                    n_fail++;
                end else begin
                    want = expected_results.pop_front();
                    n_checked++;
                    if (o_code_word !== want.code_word) begin
                        $error("code_word: expected %h, got %h", want.code_word, o_code_word);
                        n_fail++;
                    end
                    if (o_bit_count !== want.bit_count) begin
                        $error("bit_count: expected %0d, got %0d", want.bit_count, o_bit_count);
                        n_fail++;
                    end
                    if (o_value_out !== want.value_out) begin
                        $error("value_out: expected %h, got %h", want.value_out, o_value_out);
                        n_fail++;
                    end
                    if (o_error_flag !== want.error_flag) begin
                        $error("error_flag: expected %b, got %b", want.error_flag,
                               o_error_flag);
                        n_fail++;
                    end
                end
            end
            if (hold_req != hold_seen) begin
                hold_seen   <= hold_req;
                hold_cycles <= HOLD_CYCLES;
                i_ready     <= 1'b0;
            end else if (hold_cycles != 0) begin
                hold_cycles <= hold_cycles - 1;
                i_ready     <= 1'b0;
            end else begin
                i_ready <= $urandom_range(0, 99) >= recv_stall_pct;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("[elias_delta_codec] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: field extremes, both operations, every error case.
        push_item(edc_pkg::OP_ENCODE, 32'h0, '1);                  // zero value
        push_item(edc_pkg::OP_ENCODE, 32'h1, '0);
        push_item(edc_pkg::OP_ENCODE, 32'h2, '0);
        push_item(edc_pkg::OP_ENCODE, 32'h3, '1);
        push_item(edc_pkg::OP_ENCODE, 32'h4, '0);
        push_item(edc_pkg::OP_ENCODE, 32'h0000_8000, '0);          // L = 16
        push_item(edc_pkg::OP_ENCODE, 32'h0001_0000, '0);          // L = 17
        push_item(edc_pkg::OP_ENCODE, 32'h8000_0000, '0);
        push_item(edc_pkg::OP_ENCODE, 32'hFFFF_FFFF, '1);          // longest code, 42 bits
        push_item(edc_pkg::OP_DECODE, 32'hFFFF_FFFF, '0);          // all-zero window
        push_item(edc_pkg::OP_DECODE, 32'h0, '1);                  // value 1, one bit
        push_item(edc_pkg::OP_DECODE, 32'h0, 64'h2);
        push_item(edc_pkg::OP_DECODE, 32'h0, 64'h10);              // four leading zeros
        push_item(edc_pkg::OP_DECODE, 32'h0, 64'h20);              // L = 32, value 2^31
        push_item(edc_pkg::OP_DECODE, 32'h0, 64'h40);              // six leading zeros
        push_item(edc_pkg::OP_DECODE, 32'h0, 64'h8000_0000_0000_0000);
        push_item(edc_pkg::OP_DECODE, 32'h0, 64'h420);             // L = 33, oversize
        push_item(edc_pkg::OP_DECODE, 32'h0, 64'h7E0);             // L = 63, oversize
        push_item(edc_pkg::OP_DECODE, 32'h0, coded_window(32'hFFFF_FFFF));
        push_item(edc_pkg::OP_DECODE, 32'h0, coded_window(32'hA5A5_A5A5));
        push_item(edc_pkg::OP_DECODE, 32'h0, coded_window(32'h0000_0100));
        push_item(edc_pkg::OP_DECODE, 32'h0, coded_window(32'h1));
        wait_drained();

        // Full rate both ways, with one long receiver hold-off while the
        // sender keeps pushing, so the pipeline fills and drops o_ready.
        push_random(PHASE_ITEMS);
        repeat (30) @(negedge i_clk);
        hold_req++;
        wait_drained();

        send_idle_pct = 74;
        push_random(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 74;
        push_random(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 11;
        recv_stall_pct = 11;
        push_random(PHASE_ITEMS);
        wait_drained();                                   // sender pauses to empty
        push_random(300);
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("checked %0d results: %0d encodes, %0d decodes, %0d flagged as errors",
                 n_checked, n_encodes, n_decodes, n_flagged);
        $display("idle mixes covered: none, sender 74%%, receiver 74%%, both 11%%, long hold-off");
        if (n_fail == 0) begin
            $display("[elias_delta_codec] OK");
        end else begin
            $display("%0d mismatches", n_fail);
            $display("[elias_delta_codec] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
